[rtl/smap_pkg.sv]
package smap_pkg;

  localparam int unsigned HEADER_BYTES = 20;
  localparam int unsigned MIN_ADDR_ATTR_BYTES = 8;

  localparam logic [15:0] WANTED_RESET = 16'h0020;
  localparam logic [15:0] XOR_MAPPED_ADDRESS = 16'h0020;
  localparam logic [7:0] BINDING_RESP_OCTET = 8'h01;
  localparam logic [7:0] FAMILY_IPV4 = 8'h01;
  localparam logic [3:0][7:0] STUN_COOKIE = 32'h2112A442;
  localparam logic [15:0] COOKIE_PORT_MASK = 16'h2112;

  typedef enum logic [2:0] {
    ST_FOUND      = 3'd0,
    ST_SHORT      = 3'd1,
    ST_BAD_TYPE   = 3'd2,
    ST_BAD_COOKIE = 3'd3,
    ST_TXID       = 3'd4,
    ST_ATTR_SHORT = 3'd5,
    ST_NOT_FOUND  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CFG_WANTED   = 2'd0,
    CFG_TXID_HI  = 2'd1,
    CFG_TXID_MID = 2'd2,
    CFG_TXID_LO  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_VALUE   = 3'b010,
    PH_PADDING = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    SEARCH_NONE  = 2'd0,
    SEARCH_FOUND = 2'd1,
    SEARCH_SHORT = 2'd2
  } search_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] mapped_address;
    logic [15:0] mapped_port;
  } out_beat_t;

endpackage

[rtl/smap_out_buf.sv]
module smap_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  smap_pkg::out_beat_t push_data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output smap_pkg::out_beat_t out_data_o
);

  logic                main_valid_q, main_valid_d;
  logic                skid_valid_q, skid_valid_d;
  smap_pkg::out_beat_t main_q, main_d;
  smap_pkg::out_beat_t skid_q, skid_d;
  logic                drain;

  assign drain = main_valid_q && !out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // advance the held beat once the output frees up
      if (drain) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || drain) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (drain) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule

[rtl/stun_mapped_address_parser_unit.sv]
// Byte-serial STUN Binding Response parser. One datagram byte is taken per clock
// beat while in_stall_o is low, with last_byte on the final byte; exactly one
// result beat (status, mapped address, mapped port) follows each final byte and
// is registered in the output buffer; nothing is emitted for other bytes. Every
// byte is handled by compares and counter updates on the parse registers, so the
// sustained rate is one byte per clock while unstalled. A two-entry output buffer
// lets input continue while a result waits; input stalls only when both entries
// are full. Bytes beyond MAX_DATAGRAM_BYTES are ignored except for their last_byte
// flag. The user must write configuration (wanted attribute, expected transaction
// id) only while no datagram is in progress; the block itself does not enforce it.
module stun_mapped_address_parser_unit #(
  parameter int unsigned MAX_DATAGRAM_BYTES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  smap_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output smap_pkg::out_beat_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  localparam int unsigned PW = $clog2(MAX_DATAGRAM_BYTES + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_DATAGRAM_BYTES);
  localparam logic [PW-1:0] POS_HDR = PW'(smap_pkg::HEADER_BYTES);

  // configuration
  logic [15:0]       wanted_q;
  logic [11:0][7:0]  txid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q <= smap_pkg::WANTED_RESET;
      txid_q   <= '0;
    end else if (cfg_valid_i) begin
      case (smap_pkg::cfg_reg_e'(cfg_index_i))
        smap_pkg::CFG_WANTED:   wanted_q        <= cfg_data_i[15:0];
        smap_pkg::CFG_TXID_HI:  txid_q[11:8]    <= cfg_data_i;
        smap_pkg::CFG_TXID_MID: txid_q[7:4]     <= cfg_data_i;
        smap_pkg::CFG_TXID_LO:  txid_q[3:0]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // parse state
  logic [PW-1:0]             pos_q, pos_d;
  logic [15:0]               msg_len_q, msg_len_d;
  smap_pkg::status_e         hdr_err_q, hdr_err_d;  // ST_FOUND means no error
  smap_pkg::phase_e          phase_q, phase_d;
  logic [15:0]               attr_type_q, attr_type_d;
  logic [15:0]               attr_len_q, attr_len_d;
  logic [15:0]               left_q, left_d;
  logic [7:0]                family_q, family_d;
  logic [15:0]               port_q, port_d;
  logic [31:0]               addr_q, addr_d;
  logic                      done_q, done_d;
  smap_pkg::search_e         search_q, search_d;

  logic                      in_acc;
  logic [7:0]                b;
  logic [16:0]               limit;
  logic [1:0]                k;
  logic [15:0]               vi;
  logic [3:0]                txi;
  logic                      finish;
  logic [1:0]                pad;
  logic                      push;
  smap_pkg::out_beat_t       push_data;
  logic                      buf_full;

  assign in_acc     = in_valid_i && !buf_full;
  assign in_stall_o = buf_full;
  assign b          = in_data_i.data_byte;
  assign limit      = 17'(smap_pkg::HEADER_BYTES) + {1'b0, msg_len_q};
  assign k          = left_q[1:0];
  assign vi         = attr_len_q - left_q;
  assign txi        = 4'(pos_q - PW'(8));

  always_comb begin
    pos_d       = pos_q;
    msg_len_d   = msg_len_q;
    hdr_err_d   = hdr_err_q;
    phase_d     = phase_q;
    attr_type_d = attr_type_q;
    attr_len_d  = attr_len_q;
    left_d      = left_q;
    family_d    = family_q;
    port_d      = port_q;
    addr_d      = addr_q;
    done_d      = done_q;
    search_d    = search_q;
    finish      = 1'b0;
    pad         = 2'd0;
    push        = 1'b0;
    push_data   = '0;

    if (in_acc && pos_q < POS_MAX) begin
      pos_d = pos_q + PW'(1);
      if (pos_q < POS_HDR) begin
        if (pos_q < PW'(2)) begin
          if (b != smap_pkg::BINDING_RESP_OCTET && hdr_err_q == smap_pkg::ST_FOUND)
            hdr_err_d = smap_pkg::ST_BAD_TYPE;
        end else if (pos_q == PW'(2)) begin
          msg_len_d[15:8] = b;
        end else if (pos_q == PW'(3)) begin
          msg_len_d[7:0] = b;
        end else if (pos_q < PW'(8)) begin
          if (b != smap_pkg::STUN_COOKIE[2'd3 - pos_q[1:0]] &&
              hdr_err_q == smap_pkg::ST_FOUND)
            hdr_err_d = smap_pkg::ST_BAD_COOKIE;
        end else begin
          if (b != txid_q[4'd11 - txi] && hdr_err_q == smap_pkg::ST_FOUND)
            hdr_err_d = smap_pkg::ST_TXID;
        end
      end else if (!done_q && 17'(pos_q) < limit) begin
        case (phase_q)
          smap_pkg::PH_HEADER: begin
            case (k)
              2'd0:    attr_type_d[15:8] = b;
              2'd1:    attr_type_d[7:0]  = b;
              2'd2:    attr_len_d[15:8]  = b;
              default: attr_len_d[7:0]   = b;
            endcase
            left_d = 16'(k) + 16'd1;
            if (k == 2'd3) begin
              // drop the walk when the attribute overruns the message
              if (18'(pos_q) + 18'd1 + 18'(attr_len_d) > 18'(limit)) begin
                done_d = 1'b1;
              end else if (attr_len_d == '0) begin
                finish = 1'b1;
              end else begin
                phase_d = smap_pkg::PH_VALUE;
                left_d  = attr_len_d;
              end
            end
          end
          smap_pkg::PH_VALUE: begin
            if (vi == 16'd1)
              family_d = b;
            else if (vi == 16'd2 || vi == 16'd3)
              port_d = {port_q[7:0], b};
            else if (vi >= 16'd4 && vi < 16'd8)
              addr_d = {addr_q[23:0], b};
            left_d = left_q - 16'd1;
            if (left_d == '0)
              finish = 1'b1;
          end
          smap_pkg::PH_PADDING: begin
            left_d = left_q - 16'd1;
            if (left_d == '0)
              phase_d = smap_pkg::PH_HEADER;
          end
          default: phase_d = smap_pkg::PH_HEADER;
        endcase
      end
    end

    if (finish) begin
      if (attr_type_d == wanted_q && attr_len_d < 16'(smap_pkg::MIN_ADDR_ATTR_BYTES)) begin
        search_d = smap_pkg::SEARCH_SHORT;
        done_d   = 1'b1;
      end else if (attr_type_d == wanted_q && family_d == smap_pkg::FAMILY_IPV4) begin
        if (wanted_q == smap_pkg::XOR_MAPPED_ADDRESS) begin
          port_d = port_d ^ smap_pkg::COOKIE_PORT_MASK;
          addr_d = addr_d ^ smap_pkg::STUN_COOKIE;
        end
        search_d = smap_pkg::SEARCH_FOUND;
        done_d   = 1'b1;
      end else begin
        pad = 2'd0 - attr_len_d[1:0];
        if (pad != 2'd0) begin
          phase_d = smap_pkg::PH_PADDING;
          left_d  = 16'(pad);
        end else begin
          phase_d = smap_pkg::PH_HEADER;
          left_d  = '0;
        end
      end
    end

    if (in_acc && in_data_i.last_byte) begin
      push = 1'b1;
      if (pos_d < POS_HDR)
        push_data.status = smap_pkg::ST_SHORT;
      else if (hdr_err_d != smap_pkg::ST_FOUND)
        push_data.status = hdr_err_d;
      else if (search_d == smap_pkg::SEARCH_FOUND) begin
        push_data.status         = smap_pkg::ST_FOUND;
        push_data.mapped_address = addr_d;
        push_data.mapped_port    = port_d;
      end else if (search_d == smap_pkg::SEARCH_SHORT)
        push_data.status = smap_pkg::ST_ATTR_SHORT;
      else
        push_data.status = smap_pkg::ST_NOT_FOUND;

      // clear per-datagram state
      pos_d       = '0;
      msg_len_d   = '0;
      hdr_err_d   = smap_pkg::ST_FOUND;
      phase_d     = smap_pkg::PH_HEADER;
      attr_type_d = '0;
      attr_len_d  = '0;
      left_d      = '0;
      family_d    = '0;
      port_d      = '0;
      addr_d      = '0;
      done_d      = 1'b0;
      search_d    = smap_pkg::SEARCH_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      msg_len_q   <= '0;
      hdr_err_q   <= smap_pkg::ST_FOUND;
      phase_q     <= smap_pkg::PH_HEADER;
      attr_type_q <= '0;
      attr_len_q  <= '0;
      left_q      <= '0;
      family_q    <= '0;
      port_q      <= '0;
      addr_q      <= '0;
      done_q      <= 1'b0;
      search_q    <= smap_pkg::SEARCH_NONE;
    end else begin
      pos_q       <= pos_d;
      msg_len_q   <= msg_len_d;
      hdr_err_q   <= hdr_err_d;
      phase_q     <= phase_d;
      attr_type_q <= attr_type_d;
      attr_len_q  <= attr_len_d;
      left_q      <= left_d;
      family_q    <= family_d;
      port_q      <= port_d;
      addr_q      <= addr_d;
      done_q      <= done_d;
      search_q    <= search_d;
    end
  end

  smap_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
